@@ rtl/date_time_setting_menu_core_assert.svh @@
//------------------------------------------------------------------------------
// Assertion macros for the date and time setting menu
// Same-cycle and next-cycle implication checks with asynchronous reset.
//------------------------------------------------------------------------------
`ifndef DATE_TIME_SETTING_MENU_CORE_ASSERT_SVH
`define DATE_TIME_SETTING_MENU_CORE_ASSERT_SVH

// check cons in the cycle of ante
`define DTSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtsm: same-cycle check failed");

// check cons in the cycle after ante
`define DTSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtsm: next-cycle check failed");

`endif

@@ rtl/dtsm_pkg.sv @@
//------------------------------------------------------------------------------
// dtsm_pkg
// Request codes, menu item codes, field widths and calendar helpers.
//------------------------------------------------------------------------------
package dtsm_pkg;

	localparam int REQ_W    = 3;
	localparam int YEAR_W   = 16;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int MENU_W   = 3;
	localparam int SHOWN_W  = 16;
	localparam int BRIGHT_W = 4;

	localparam int IN_BITS  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = IN_BITS + MENU_W + SHOWN_W + 1 + 1 + BRIGHT_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [REQ_W-1:0] REQ_SHOW  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PLUS  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MINUS = 3'd2;
	localparam logic [REQ_W-1:0] REQ_NEXT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RESET = 3'd4;

	localparam logic [MENU_W-1:0] ITEM_YEAR   = 3'd0;
	localparam logic [MENU_W-1:0] ITEM_MONTH  = 3'd1;
	localparam logic [MENU_W-1:0] ITEM_DAY    = 3'd2;
	localparam logic [MENU_W-1:0] ITEM_MODE   = 3'd3;
	localparam logic [MENU_W-1:0] ITEM_HOUR   = 3'd4;
	localparam logic [MENU_W-1:0] ITEM_MINUTE = 3'd5;
	localparam logic [MENU_W-1:0] ITEM_SECOND = 3'd6;
	localparam logic [MENU_W-1:0] ITEM_BRIGHT = 3'd7;

	localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 4'd15;
	localparam logic [HOUR_W-1:0]   HOUR_TOP     = 5'd23;
	localparam logic [MIN_W-1:0]    MIN_TOP      = 6'd59;

	// floor(y / 25) = (y * DIV25_MUL) >> DIV25_SH for all 16-bit y
	localparam logic [16:0] DIV25_MUL = 17'd83887;
	localparam int          DIV25_SH  = 21;

	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		logic [32:0]       prod;
		logic [11:0]       q;
		logic [YEAR_W-1:0] q25;
		logic              div25;
		prod  = y * DIV25_MUL;
		q     = prod[DIV25_SH +: 12];
		q25   = {q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q};
		div25 = (q25 == y);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/date_time_setting_menu_core.sv @@
// One register stage holds the accepted item, one the result, registered as the item leaves.
// Throughput: one item per cycle while the output is not stalled by m_axis_tready.
// The menu index, 24-hour mode and brightness update as an item leaves the input stage.
// Reset (arst_n low, asynchronous) empties both stages, sets the menu to year,
// twelve-hour mode and full brightness.
//------------------------------------------------------------------------------
// date_time_setting_menu_core
// Button-event editor for calendar date, time, hour mode and brightness.
//------------------------------------------------------------------------------
`include "date_time_setting_menu_core_assert.svh"

module date_time_setting_menu_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// year[15:0] month[19:16] day[24:20] hour[29:25] minute[35:30] second[41:36]
	input  logic [dtsm_pkg::IN_W-1:0]    s_axis_tdata,
	// req_type[2:0]
	input  logic [dtsm_pkg::REQ_W-1:0]   s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// year[15:0] month[19:16] day[24:20] hour[29:25] minute[35:30] second[41:36]
	// menu_item[44:42] shown_value[60:45] shows_pm[61] mode_24h[62]
	// brightness_level[66:63] bright_updated[67]
	output logic [dtsm_pkg::OUT_W-1:0]   m_axis_tdata
);

	logic                             valid_s1;
	logic                             adv_s1;
	logic [dtsm_pkg::REQ_W-1:0]       req_s1;
	logic [dtsm_pkg::YEAR_W-1:0]      year_s1;
	logic [dtsm_pkg::MONTH_W-1:0]     month_s1;
	logic [dtsm_pkg::DAY_W-1:0]       day_s1;
	logic [dtsm_pkg::HOUR_W-1:0]      hour_s1;
	logic [dtsm_pkg::MIN_W-1:0]       minute_s1;
	logic [dtsm_pkg::SEC_W-1:0]       second_s1;

	logic [dtsm_pkg::MENU_W-1:0]      menu_q;
	logic                             mode_q;
	logic [dtsm_pkg::BRIGHT_W-1:0]    bright_q;
	logic                             out_valid_q;
	logic [dtsm_pkg::OUT_W-1:0]       out_data_q;

	logic                             plus;
	logic                             minus;
	logic                             edit;
	logic                             leap;
	logic [dtsm_pkg::MONTH_W-1:0]     month_step;
	logic [dtsm_pkg::DAY_W-1:0]       maxd_cur;
	logic [dtsm_pkg::DAY_W-1:0]       maxd_new;
	logic [dtsm_pkg::YEAR_W-1:0]      year_n;
	logic [dtsm_pkg::MONTH_W-1:0]     month_n;
	logic [dtsm_pkg::DAY_W-1:0]       day_n;
	logic [dtsm_pkg::HOUR_W-1:0]      hour_n;
	logic [dtsm_pkg::MIN_W-1:0]       minute_n;
	logic [dtsm_pkg::SEC_W-1:0]       second_n;
	logic [dtsm_pkg::MENU_W-1:0]      menu_n;
	logic                             mode_n;
	logic [dtsm_pkg::BRIGHT_W-1:0]    bright_n;
	logic [dtsm_pkg::SHOWN_W-1:0]     shown;
	logic                             pm;
	logic                             bchg;
	logic [dtsm_pkg::OUT_BITS-1:0]    result;

	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1    <= s_axis_tuser;
			year_s1   <= s_axis_tdata[15:0];
			month_s1  <= s_axis_tdata[19:16];
			day_s1    <= s_axis_tdata[24:20];
			hour_s1   <= s_axis_tdata[29:25];
			minute_s1 <= s_axis_tdata[35:30];
			second_s1 <= s_axis_tdata[41:36];
		end
	end

	assign plus       = (req_s1 == dtsm_pkg::REQ_PLUS);
	assign minus      = (req_s1 == dtsm_pkg::REQ_MINUS);
	assign edit       = plus || minus || (req_s1 == dtsm_pkg::REQ_SHOW);
	assign leap       = dtsm_pkg::leap_year(year_s1);
	assign month_step = plus ? ((month_s1 >= 4'd12) ? 4'd1 : month_s1 + 4'd1)
		: ((month_s1 <= 4'd1) ? 4'd12 : month_s1 - 4'd1);
	assign maxd_cur   = dtsm_pkg::month_len(month_s1, leap);
	assign maxd_new   = dtsm_pkg::month_len(month_step, leap);

	always_comb begin
		year_n   = year_s1;
		month_n  = month_s1;
		day_n    = day_s1;
		hour_n   = hour_s1;
		minute_n = minute_s1;
		second_n = second_s1;
		menu_n   = menu_q;
		mode_n   = mode_q;
		bright_n = bright_q;
		shown    = '0;
		pm       = 1'b0;
		bchg     = 1'b0;
		if (req_s1 == dtsm_pkg::REQ_NEXT) begin
			menu_n = menu_q + 3'd1;
		end else if (req_s1 == dtsm_pkg::REQ_RESET) begin
			menu_n = dtsm_pkg::ITEM_YEAR;
		end else if (edit) begin
			unique case (menu_q)
				dtsm_pkg::ITEM_YEAR: begin
					shown = year_s1;
					if (plus || minus) begin
						year_n = plus ? year_s1 + 16'd1 : year_s1 - 16'd1;
						if (month_s1 == 4'd2 && day_s1 == 5'd29) begin
							day_n = 5'd28;
						end
					end
				end
				dtsm_pkg::ITEM_MONTH: begin
					shown = {12'd0, month_s1};
					if (plus || minus) begin
						month_n = month_step;
						if (day_s1 > maxd_new) begin
							day_n = maxd_new;
						end
					end
				end
				dtsm_pkg::ITEM_DAY: begin
					shown = {11'd0, day_s1};
					if (plus) begin
						day_n = (day_s1 >= maxd_cur) ? 5'd1 : day_s1 + 5'd1;
					end else if (minus) begin
						day_n = (day_s1 <= 5'd1 || day_s1 > maxd_cur) ? maxd_cur
							: day_s1 - 5'd1;
					end
				end
				dtsm_pkg::ITEM_MODE: begin
					shown = mode_q ? 16'd24 : 16'd12;
					if (plus || minus) begin
						mode_n = !mode_q;
					end
				end
				dtsm_pkg::ITEM_HOUR: begin
					if (mode_q) begin
						shown = {11'd0, hour_s1};
					end else if (hour_s1 >= 5'd12) begin
						pm    = 1'b1;
						shown = {11'd0, (hour_s1 >= 5'd13) ? hour_s1 - 5'd12 : hour_s1};
					end else begin
						shown = {11'd0, (hour_s1 == 5'd0) ? 5'd12 : hour_s1};
					end
					if (plus) begin
						hour_n = (hour_s1 >= dtsm_pkg::HOUR_TOP) ? 5'd0 : hour_s1 + 5'd1;
					end else if (minus) begin
						hour_n = (hour_s1 == 5'd0 || hour_s1 > dtsm_pkg::HOUR_TOP)
							? dtsm_pkg::HOUR_TOP : hour_s1 - 5'd1;
					end
				end
				dtsm_pkg::ITEM_MINUTE: begin
					shown = {10'd0, minute_s1};
					if (plus) begin
						minute_n = (minute_s1 >= dtsm_pkg::MIN_TOP) ? 6'd0
							: minute_s1 + 6'd1;
					end else if (minus) begin
						minute_n = (minute_s1 == 6'd0 || minute_s1 > dtsm_pkg::MIN_TOP)
							? dtsm_pkg::MIN_TOP : minute_s1 - 6'd1;
					end
				end
				dtsm_pkg::ITEM_SECOND: begin
					shown = {10'd0, second_s1};
					if (plus) begin
						second_n = (second_s1 >= dtsm_pkg::MIN_TOP) ? 6'd0
							: second_s1 + 6'd1;
					end else if (minus) begin
						second_n = (second_s1 == 6'd0 || second_s1 > dtsm_pkg::MIN_TOP)
							? dtsm_pkg::MIN_TOP : second_s1 - 6'd1;
					end
				end
				default: begin
					shown = {12'd0, bright_q};
					if (plus) begin
						bright_n = bright_q + 4'd1;
						bchg     = 1'b1;
					end else if (minus) begin
						bright_n = bright_q - 4'd1;
						bchg     = 1'b1;
					end
				end
			endcase
		end
	end

	assign result = {bchg, bright_n, mode_n, pm, shown, menu_n,
		second_n, minute_n, hour_n, day_n, month_n, year_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q      <= dtsm_pkg::ITEM_YEAR;
			mode_q      <= 1'b0;
			bright_q    <= dtsm_pkg::BRIGHT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				menu_q   <= menu_n;
				mode_q   <= mode_n;
				bright_q <= bright_n;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {{(dtsm_pkg::OUT_W - dtsm_pkg::OUT_BITS){1'b0}}, result};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`DTSM_ASSERT_SAME(a_bchg_item, clk, arst_n, m_axis_tvalid && m_axis_tdata[67], m_axis_tdata[44:42] == dtsm_pkg::ITEM_BRIGHT)
	`DTSM_ASSERT_SAME(a_pm_hour, clk, arst_n, m_axis_tvalid && m_axis_tdata[61], !m_axis_tdata[62] && m_axis_tdata[44:42] == dtsm_pkg::ITEM_HOUR)
	`DTSM_ASSERT_SAME(a_stall, clk, arst_n, !s_axis_tready, valid_s1 && out_valid_q && !m_axis_tready)
	`DTSM_ASSERT_NEXT(a_menu_next, clk, arst_n, adv_s1 && req_s1 == dtsm_pkg::REQ_NEXT, menu_q == $past(menu_q) + 3'd1)

endmodule
